// File: design/dtw_distance_engine_macros.svh
// Assertion macros for the warping cost engine.
`ifndef DTW_DISTANCE_ENGINE_MACROS_SVH
`define DTW_DISTANCE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define DTW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtw assertion failed");
`define DTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtw assertion failed");
`else
`define DTW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DTW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/dtw_pkg.sv
`default_nettype none

package dtw_pkg;

  localparam int DTW_MAX_REF = 256;
  localparam int DTW_COORD_W = 16;
  localparam int QPOS_W      = 16;

  localparam logic [31:0] INF_COST = 32'hFFFF_FFFF;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_INF   = 2'd1;
  localparam logic [1:0] STATUS_NOREF = 2'd2;

  localparam logic KIND_REF   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

`default_nettype wire

// File: design/dtw_if.sv
`default_nettype none

interface dtw_in_if #(parameter int COORD_WIDTH = dtw_pkg::DTW_COORD_W);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [COORD_WIDTH-1:0] x;
  logic signed [COORD_WIDTH-1:0] y;
  logic                          last;
  modport source (output valid, kind, x, y, last, input ready);
  modport sink   (input valid, kind, x, y, last, output ready);
endinterface

interface dtw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic [1:0]  status;
  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

`default_nettype wire

// File: design/dtw_sqrt_pipe.sv
`default_nettype none

// Integer square root, one result bit per stage, truncating toward zero.
module dtw_sqrt_pipe #(
  parameter int RW = 18,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [2*RW-1:0] in_rad,
  input  logic [TW-1:0]   in_tag,
  output logic            out_vld,
  output logic [RW-1:0]   out_root,
  output logic [TW-1:0]   out_tag
);

  logic            vld_r  [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r  [RW];
  logic [TW-1:0]   tag_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            vld_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] rad_in;
    logic [TW-1:0]   tag_in;
    logic [RW+3:0]   rem_t;
    logic [RW+3:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    assign rem_t = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (RW+2)'(rem_t - trial) : (RW+2)'(rem_t);
      root_r[k] <= {root_in[RW-2:0], ge};
      rad_r[k]  <= rad_in << 2;
      tag_r[k]  <= tag_in;
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_tag  = tag_r[RW-1];

endmodule

`default_nettype wire

// File: design/dtw_distance_engine.sv
`default_nettype none

// Dynamic time warping engine over a stored reference path. A reference
// point (kind 0) is written to the reference store when it is accepted. The
// first point of a query fills column cells 1 to N-1 with infinity, N being
// the reference length. Each later query point streams the N-1 column cells
// through the cost memory read port at one cell per cycle, then waits for
// the distance pipeline (three arithmetic stages plus one square root stage
// per result bit, 18 at 16-bit coordinates) to drain. A result item comes
// out of the last query point and waits in an output register.
module dtw_distance_engine #(
  parameter int MAX_REFERENCE_POINTS = dtw_pkg::DTW_MAX_REF,
  parameter int COORD_WIDTH          = dtw_pkg::DTW_COORD_W
) (
  input  logic             clk,
  input  logic             rst_n,
  dtw_in_if.sink           in_ch,
  dtw_out_if.source        out_ch
);
  import dtw_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = $clog2(MAX_REFERENCE_POINTS);
  localparam int LW   = $clog2(MAX_REFERENCE_POINTS + 1);
  localparam int DW   = CW + 1;
  localparam int SQW  = 2 * DW;
  localparam int SUMW = SQW + 1;
  localparam int SW   = (SUMW > 64) ? 64 : SUMW;
  localparam int RW   = (SW + 1) / 2;
  localparam int TW   = 1 + AW + 32;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INIT  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             st_r, st_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic               cmpl_r, cmpl_nxt;
  logic [QPOS_W-1:0]  qpos_r, qpos_nxt;
  logic               last_r, last_nxt;
  logic signed [CW-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               col0_zero_r, col0_zero_nxt;
  logic [31:0]        prev_new_r, prev_new_nxt, prev_old_r, prev_old_nxt;
  logic [31:0]        res_d_r, res_d_nxt;
  logic [1:0]         res_s_r, res_s_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [31:0]        out_dist_r, out_dist_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;

  logic               in_fire, loaded;
  logic [LW-1:0]      base_len;
  logic [AW-1:0]      last_idx;
  logic               ref_we, col_we, rd_en;
  logic [AW-1:0]      ref_wa, col_wa;
  logic [31:0]        col_wd;

  logic [2*CW-1:0]    ref_mem [MAX_REFERENCE_POINTS];
  logic [31:0]        col_mem [MAX_REFERENCE_POINTS];
  logic [2*CW-1:0]    ref_q_r;
  logic [31:0]        col_q_r;

  logic               p0_vld_r, pa_vld_r, pb_vld_r, pc_vld_r;
  logic               p0_last_r;
  logic [AW-1:0]      p0_idx_r;
  logic [TW-1:0]      pa_tag_r, pb_tag_r, pc_tag_r;
  logic [DW-1:0]      dx_r, dy_r;
  logic [SQW-1:0]     sqx_r, sqy_r;
  logic [2*RW-1:0]    rad_r;
  logic signed [DW-1:0] rx_e, ry_e, qx_e, qy_e;
  logic [SUMW-1:0]    sum_full;
  logic [SW-1:0]      sum_sat;

  logic               acc_vld;
  logic [RW-1:0]      acc_root;
  logic [TW-1:0]      acc_tag;
  logic [31:0]        acc_old, acc_dist, acc_best, acc_min, acc_cell;
  logic [32:0]        acc_sum;
  logic               acc_last;
  logic [AW-1:0]      acc_idx;

  function automatic logic [1:0] cost_status(input logic [31:0] d);
    return (d == INF_COST) ? STATUS_INF : STATUS_OK;
  endfunction

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);
  assign loaded    = cmpl_r && (len_r != '0);
  assign base_len  = cmpl_r ? '0 : len_r;
  assign last_idx  = AW'(len_r - 1'b1);

  // Cost accumulation: the only feedback loop is the chain from the previous
  // cell (prev_new_r) through min and saturating add.
  assign acc_old  = acc_tag[31:0];
  assign acc_idx  = acc_tag[32 +: AW];
  assign acc_last = acc_tag[TW-1];
  assign acc_dist = 32'(acc_root);
  assign acc_min  = (prev_new_r < acc_old) ? prev_new_r : acc_old;
  assign acc_best = (prev_old_r < acc_min) ? prev_old_r : acc_min;
  assign acc_sum  = {1'b0, acc_dist} + {1'b0, acc_best};
  assign acc_cell = (acc_sum[32] || (&acc_sum[31:0])) ? INF_COST : acc_sum[31:0];

  always_comb begin
    st_nxt        = st_r;
    len_nxt       = len_r;
    cmpl_nxt      = cmpl_r;
    qpos_nxt      = qpos_r;
    last_nxt      = last_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    idx_nxt       = idx_r;
    col0_zero_nxt = col0_zero_r;
    prev_new_nxt  = prev_new_r;
    prev_old_nxt  = prev_old_r;
    res_d_nxt     = res_d_r;
    res_s_nxt     = res_s_r;
    ref_we        = 1'b0;
    ref_wa        = base_len[AW-1:0];
    col_we        = 1'b0;
    col_wa        = idx_r;
    col_wd        = INF_COST;
    rd_en         = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == KIND_REF) begin
            qpos_nxt = '0;
            cmpl_nxt = in_ch.last;
            len_nxt  = base_len;
            if (base_len < LW'(MAX_REFERENCE_POINTS)) begin
              ref_we  = 1'b1;
              len_nxt = base_len + 1'b1;
            end
          end else begin
            last_nxt = in_ch.last;
            qx_nxt   = CW'(in_ch.x);
            qy_nxt   = CW'(in_ch.y);
            if (in_ch.last) begin
              qpos_nxt = '0;
            end else if (!(&qpos_r)) begin
              qpos_nxt = qpos_r + 1'b1;
            end
            if (!loaded) begin
              if (in_ch.last) begin
                res_d_nxt = INF_COST;
                res_s_nxt = STATUS_NOREF;
                st_nxt    = S_DONE;
              end
            end else if (qpos_r == '0) begin
              col0_zero_nxt = 1'b1;
              idx_nxt       = AW'(1);
              if (len_r == LW'(1)) begin
                res_d_nxt = '0;
                res_s_nxt = STATUS_OK;
                if (in_ch.last) begin
                  st_nxt = S_DONE;
                end
              end else begin
                st_nxt = S_INIT;
              end
            end else begin
              col0_zero_nxt = 1'b0;
              prev_old_nxt  = col0_zero_r ? '0 : INF_COST;
              prev_new_nxt  = INF_COST;
              idx_nxt       = AW'(1);
              if (len_r == LW'(1)) begin
                res_d_nxt = INF_COST;
                res_s_nxt = STATUS_INF;
                if (in_ch.last) begin
                  st_nxt = S_DONE;
                end
              end else begin
                st_nxt = S_RUN;
              end
            end
          end
        end
      end
      S_INIT: begin
        col_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == last_idx) begin
          res_d_nxt = INF_COST;
          res_s_nxt = STATUS_INF;
          st_nxt    = last_r ? S_DONE : S_IDLE;
        end
      end
      S_RUN: begin
        rd_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == last_idx) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
      end
      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (acc_vld) begin
      col_we       = 1'b1;
      col_wa       = acc_idx;
      col_wd       = acc_cell;
      prev_new_nxt = acc_cell;
      prev_old_nxt = acc_old;
      if (acc_last) begin
        res_d_nxt = acc_cell;
        res_s_nxt = cost_status(acc_cell);
        st_nxt    = last_r ? S_DONE : S_IDLE;
      end
    end
  end

  always_comb begin
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_dist_nxt = out_dist_r;
    out_stat_nxt = out_stat_r;
    if (st_r == S_DONE && (!out_vld_r || out_ch.ready)) begin
      out_vld_nxt  = 1'b1;
      out_dist_nxt = res_d_r;
      out_stat_nxt = res_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      len_r     <= '0;
      cmpl_r    <= 1'b0;
      qpos_r    <= '0;
      out_vld_r <= 1'b0;
      p0_vld_r  <= 1'b0;
      pa_vld_r  <= 1'b0;
      pb_vld_r  <= 1'b0;
      pc_vld_r  <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      len_r     <= len_nxt;
      cmpl_r    <= cmpl_nxt;
      qpos_r    <= qpos_nxt;
      out_vld_r <= out_vld_nxt;
      p0_vld_r  <= rd_en;
      pa_vld_r  <= p0_vld_r;
      pb_vld_r  <= pa_vld_r;
      pc_vld_r  <= pb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    qx_r        <= qx_nxt;
    qy_r        <= qy_nxt;
    idx_r       <= idx_nxt;
    col0_zero_r <= col0_zero_nxt;
    prev_new_r  <= prev_new_nxt;
    prev_old_r  <= prev_old_nxt;
    res_d_r     <= res_d_nxt;
    res_s_r     <= res_s_nxt;
    out_dist_r  <= out_dist_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // Reference store: y in the upper half, x in the lower half.
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= {in_ch.y, in_ch.x};
    end
    if (rd_en) begin
      ref_q_r <= ref_mem[idx_r];
    end
  end

  // Cost column. Reads run ahead of the write-back and always target later
  // cells of the same column, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= col_wd;
    end
    if (rd_en) begin
      col_q_r <= col_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    p0_idx_r  <= idx_r;
    p0_last_r <= (idx_r == last_idx);
  end

  assign rx_e = DW'($signed(ref_q_r[CW-1:0]));
  assign ry_e = DW'($signed(ref_q_r[2*CW-1:CW]));
  assign qx_e = DW'(qx_r);
  assign qy_e = DW'(qy_r);

  always_ff @(posedge clk) begin
    dx_r     <= (rx_e >= qx_e) ? DW'(rx_e - qx_e) : DW'(qx_e - rx_e);
    dy_r     <= (ry_e >= qy_e) ? DW'(ry_e - qy_e) : DW'(qy_e - ry_e);
    pa_tag_r <= {p0_last_r, p0_idx_r, col_q_r};
  end

  always_ff @(posedge clk) begin
    sqx_r    <= dx_r * dx_r;
    sqy_r    <= dy_r * dy_r;
    pb_tag_r <= pa_tag_r;
  end

  assign sum_full = SUMW'(sqx_r) + SUMW'(sqy_r);
  assign sum_sat  = (|(sum_full >> SW)) ? '1 : SW'(sum_full);

  always_ff @(posedge clk) begin
    rad_r    <= (2*RW)'(sum_sat);
    pc_tag_r <= pb_tag_r;
  end

  dtw_sqrt_pipe #(
    .RW (RW),
    .TW (TW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (pc_vld_r),
    .in_rad   (rad_r),
    .in_tag   (pc_tag_r),
    .out_vld  (acc_vld),
    .out_root (acc_root),
    .out_tag  (acc_tag)
  );

  assign out_ch.valid    = out_vld_r;
  assign out_ch.distance = out_dist_r;
  assign out_ch.status   = out_stat_r;

`include "dtw_distance_engine_macros.svh"

  `DTW_ASSERT_IMPL(a_run_idx, clk, rst_n, st_r == S_RUN, idx_r != '0 && LW'(idx_r) < len_r)
  `DTW_ASSERT_IMPL(a_acc_state, clk, rst_n, acc_vld, st_r == S_RUN || st_r == S_DRAIN)
  `DTW_ASSERT_NEXT(a_done_out, clk, rst_n, st_r == S_DONE && (!out_vld_r || out_ch.ready), out_vld_r)
  `DTW_ASSERT_IMPL(a_len_cap, clk, rst_n, 1'b1, len_r <= LW'(MAX_REFERENCE_POINTS))

endmodule

`default_nettype wire

// File: tb/tb_dtw_distance_engine.sv
`timescale 1ns / 100ps

module tb_dtw_distance_engine;
  import dtw_pkg::*;

  localparam int MAX_PTS = DTW_MAX_REF;
  localparam int CW = DTW_COORD_W;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 600;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
    logic          typed;
    logic [31:0]   cost;
    logic [1:0]    status;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] cost;
    logic [1:0]  status;
  } warp_result_t;

  localparam int NUM_DIRECTED = 22;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{KIND_QUERY, 16'sd0,      16'sd0,      1'b1, 1'b1, INF_COST, STATUS_NOREF},
    '{KIND_REF,   16'sd0,      16'sd0,      1'b1, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd100,    -16'sd100,   1'b1, 1'b1, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd5,      16'sd5,      1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd7,      16'sd7,      1'b1, 1'b1, INF_COST, STATUS_INF},
    '{KIND_REF,   -16'sd32768, -16'sd32768, 1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_REF,   16'sd32767,  16'sd32767,  1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_REF,   16'sd0,      -16'sd32768, 1'b1, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd1,      16'sd1,      1'b1, 1'b1, INF_COST, STATUS_INF},
    '{KIND_QUERY, -16'sd32768, 16'sd32767,  1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd32767,  -16'sd32768, 1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd0,      16'sd0,      1'b1, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd1234,   -16'sd4321,  1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_REF,   16'sd16,     16'sd16,     1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_REF,   -16'sd16,    16'sd16,     1'b1, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd0,      16'sd0,      1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd32767,  16'sd32767,  1'b1, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_REF,   16'sd1,      16'sd2,      1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd3,      16'sd4,      1'b1, 1'b1, INF_COST, STATUS_NOREF},
    '{KIND_REF,   16'sd5,      16'sd6,      1'b1, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, 16'sd0,      16'sd0,      1'b0, 1'b0, 32'd0,    STATUS_OK},
    '{KIND_QUERY, -16'sd1,     -16'sd1,     1'b1, 1'b0, 32'd0,    STATUS_OK}
  };

  logic clk;
  logic rst_n;

  dtw_in_if #(.COORD_WIDTH(CW)) in_ch ();
  dtw_out_if out_ch ();

  dtw_distance_engine #(
    .MAX_REFERENCE_POINTS(MAX_PTS),
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Shadow copy of the engine state.
  logic signed [CW-1:0] path_x [MAX_PTS];
  logic signed [CW-1:0] path_y [MAX_PTS];
  logic [31:0] cost_col [MAX_PTS];
  int unsigned path_len;
  bit path_done;
  int unsigned query_pos;

  warp_result_t expected_results[$];
  int errors;
  bit sender_done;
  bit hold_request;
  int items_sent;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] point_gap(input logic signed [CW-1:0] ax,
                                            input logic signed [CW-1:0] ay,
                                            input logic signed [CW-1:0] bx,
                                            input logic signed [CW-1:0] by);
    longint dx;
    longint dy;
    logic [63:0] r;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    r = int_sqrt(64'(dx * dx) + 64'(dy * dy));
    return (r >= 64'(INF_COST)) ? INF_COST : r[31:0];
  endfunction

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, INF_COST}) ? INF_COST : s[31:0];
  endfunction

  // Applies one accepted item to the shadow state; returns 1 when it yields a result.
  function automatic bit warp_step(input logic kind, input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y, input logic last,
                                   output warp_result_t res);
    bit loaded;
    logic [31:0] prev_old;
    logic [31:0] prev_new;
    logic [31:0] old_val;
    logic [31:0] best;
    res = '0;
    if (kind == KIND_REF) begin
      if (path_done) begin
        path_done = 0;
        path_len = 0;
      end
      query_pos = 0;
      if (path_len < MAX_PTS) begin
        path_x[path_len] = x;
        path_y[path_len] = y;
        path_len++;
      end
      if (last) path_done = 1;
      return 0;
    end
    loaded = path_done && path_len > 0;
    if (loaded) begin
      if (query_pos == 0) begin
        cost_col[0] = 0;
        for (int i = 1; i < path_len; i++) cost_col[i] = INF_COST;
      end else begin
        prev_old = cost_col[0];
        prev_new = INF_COST;
        cost_col[0] = INF_COST;
        for (int i = 1; i < path_len; i++) begin
          old_val = cost_col[i];
          best = (prev_new < old_val) ? prev_new : old_val;
          if (prev_old < best) best = prev_old;
          cost_col[i] = sat_sum(point_gap(path_x[i], path_y[i], x, y), best);
          prev_old = old_val;
          prev_new = cost_col[i];
        end
      end
    end
    if (query_pos < 32'hFFFF) query_pos++;
    if (!last) return 0;
    query_pos = 0;
    if (!loaded) begin
      res.cost = INF_COST;
      res.status = STATUS_NOREF;
    end else begin
      res.cost = cost_col[path_len-1];
      res.status = (res.cost == INF_COST) ? STATUS_INF : STATUS_OK;
    end
    return 1;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic send_point(input logic kind, input logic [CW-1:0] x,
                            input logic [CW-1:0] y, input logic last,
                            input bit typed, input warp_result_t typed_res);
    int gap;
    warp_result_t res;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.x <= x;
    in_ch.y <= y;
    in_ch.last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (warp_step(kind, x, y, last, res)) begin
      if (typed) expected_results = {expected_results, typed_res};
      else expected_results = {expected_results, res};
    end
  endtask

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return CW'($urandom_range(0, 63)) - CW'(32);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_random(input logic kind, input logic last);
    send_point(kind, pick_coord(), pick_coord(), last, 1'b0, '0);
  endtask

  initial begin
    int plen;
    int nq;
    int qlen;
    int big_refs;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.kind = KIND_REF;
    in_ch.x = '0;
    in_ch.y = '0;
    in_ch.last = 0;
    path_len = 0;
    path_done = 0;
    query_pos = 0;
    errors = 0;
    sender_done = 0;
    hold_request = 0;
    items_sent = 0;
    big_refs = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_point(DIRECTED[r].kind, DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].last,
                 DIRECTED[r].typed, '{cost: DIRECTED[r].cost, status: DIRECTED[r].status});
    end

    hold_request <= 1'b1;
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: send_random(KIND_QUERY, 1'($urandom_range(0, 1)));
        1: begin
          // Unfinished reference, so the queries that follow see no reference.
          plen = $urandom_range(1, 4);
          for (int i = 0; i < plen; i++) send_random(KIND_REF, 1'b0);
          send_random(KIND_QUERY, 1'($urandom_range(0, 1)));
        end
        2: begin
          // Query cut short by a reference point.
          send_random(KIND_QUERY, 1'b0);
          send_random(KIND_QUERY, 1'b0);
          send_random(KIND_REF, 1'($urandom_range(0, 1)));
        end
        default: begin
          if (big_refs < 2 && $urandom_range(0, 29) == 0 &&
              items_sent + MAX_PTS + 16 < NUM_DIRECTED + RANDOM_ITEMS) begin
            big_refs++;
            plen = (big_refs == 1) ? MAX_PTS : MAX_PTS + 5;
          end else begin
            plen = $urandom_range(1, 12);
          end
          for (int i = 0; i < plen; i++) send_random(KIND_REF, i == plen - 1);
          nq = $urandom_range(1, 3);
          for (int q = 0; q < nq; q++) begin
            qlen = (plen > 20) ? $urandom_range(1, 3) : $urandom_range(1, 10);
            for (int i = 0; i < qlen; i++) send_random(KIND_QUERY, i == qlen - 1);
          end
        end
      endcase
    end
    in_ch.valid <= 1'b0;
    sender_done = 1;
  end

  initial begin
    int stall;
    warp_result_t exp_res;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result distance=%h status=%0d", $time,
                 out_ch.distance, out_ch.status);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_ch.distance !== exp_res.cost) begin
          $display("%0t: distance expected %h actual %h", $time, exp_res.cost,
                   out_ch.distance);
          errors++;
        end
        if (out_ch.status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                   out_ch.status);
          errors++;
        end
      end
    end
  end

  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL dtw_distance_engine");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (sender_done);
    wait (expected_results.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS dtw_distance_engine");
    end else begin
      $display("FAIL dtw_distance_engine");
    end
    $finish;
  end

endmodule
